/* src/lupp_pkg.sv */
// ----------------------------------------------------------------------------
// lupp_pkg
// shared types, constants and helpers for the lu factorization block
// ----------------------------------------------------------------------------
package lupp_pkg;

    localparam int MAX_DIM = 8;
    localparam int IDX_W   = 3;
    localparam int DIM_W   = 4;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [DIM_W-1:0]  dim_t;
    typedef logic signed [31:0] word_t;

    localparam word_t ONE_Q16  = 32'sh0001_0000;
    localparam word_t ZERO_Q16 = 32'sh0000_0000;
    localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
    localparam word_t WORD_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic  w_we;
        logic  l_we;
        idx_t  wr_cell;
        idx_t  wr_col;
        word_t wr_data;
        idx_t  rd_col;
        logic  lpos_init;
        logic  swap_en;
        idx_t  swap_a;
        idx_t  swap_b;
        idx_t  find_pos;
        idx_t  k;
        dim_t  n;
    } cell_ctl_t;

    typedef struct packed {
        logic        found;
        logic [31:0] best_abs;
        idx_t        best_pos;
        idx_t        best_cell;
    } chain_t;

    function automatic logic [31:0] abs_word(input word_t v);
        logic [31:0] r;
        r = v[31] ? (~v + 32'd1) : v;
        return r;
    endfunction

    function automatic word_t sat_word(input logic signed [48:0] v);
        word_t r;
        if (v > 49'sh0_7FFF_FFFF)
            r = WORD_MAX;
        else if (v < -49'sh0_8000_0000)
            r = WORD_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

/* src/lu_decomposition_partial_pivot.sv */
// ----------------------------------------------------------------------------
// lu_decomposition_partial_pivot
// P*A = L*U factorization with partial pivoting in signed Q15.16
// ----------------------------------------------------------------------------
// usage:
//   cfg_wr_en/cfg_wr_data set the matrix size n (0 acts as 1, above 8 as 8)
//   and drop any partial load; write only while busy is low
//   a word is taken on each clock edge with start high and busy low, row-major
//   busy stays low during the load; after the n*n-th word busy rises and
//   the factorization runs: per column a pivot search down the row cells,
//   then per row below the pivot a 48-step divide, and a multiply and a
//   subtract per updated element
//   results: n*n words, row-major, each shown for one cycle with
//   result_valid high; last marks the final one
//   a zero pivot column gives a single word with singular and last high
//   busy falls with the last result; the next word starts a new matrix
//   the receiver cannot stall, so results are never held
//   reset: size 8, load empty, no result pending
// ----------------------------------------------------------------------------
module lu_decomposition_partial_pivot (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic signed [31:0] element,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,
    output logic        result_valid,
    output logic [2:0]  row_index,
    output logic [2:0]  col_index,
    output logic signed [31:0] lower_value,
    output logic signed [31:0] upper_value,
    output logic [2:0]  original_row,
    output logic        singular,
    output logic        last
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SEARCH = 4'd1;
    localparam logic [3:0] S_PIVOT  = 4'd2;
    localparam logic [3:0] S_ROW    = 4'd3;
    localparam logic [3:0] S_DSTART = 4'd4;
    localparam logic [3:0] S_DIV    = 4'd5;
    localparam logic [3:0] S_MUL    = 4'd6;
    localparam logic [3:0] S_SUB    = 4'd7;
    localparam logic [3:0] S_OROW   = 4'd8;
    localparam logic [3:0] S_OCOL   = 4'd9;

    localparam int DIM = lupp_pkg::MAX_DIM;

    logic [3:0]          state_reg;
    lupp_pkg::dim_t      n_reg;
    lupp_pkg::dim_t      ld_row_reg;
    lupp_pkg::dim_t      ld_col_reg;
    lupp_pkg::dim_t      k_reg;
    lupp_pkg::dim_t      i_reg;
    lupp_pkg::dim_t      j_reg;
    lupp_pkg::dim_t      cnt_reg;
    lupp_pkg::idx_t      piv_cell_reg;
    lupp_pkg::idx_t      cur_cell_reg;
    lupp_pkg::word_t     pv_reg;
    lupp_pkg::word_t     lq_reg;
    lupp_pkg::word_t     a_reg;
    logic signed [63:0]  prod_reg;

    logic                result_valid_reg;
    logic [2:0]          row_index_reg;
    logic [2:0]          col_index_reg;
    lupp_pkg::word_t     lower_value_reg;
    lupp_pkg::word_t     upper_value_reg;
    logic [2:0]          original_row_reg;
    logic                singular_reg;
    logic                last_reg;

    lupp_pkg::cell_ctl_t ctl;
    lupp_pkg::chain_t    chain_link [DIM+1];
    lupp_pkg::word_t     cell_w [DIM];
    lupp_pkg::word_t     cell_l [DIM];
    logic [DIM-1:0]      cell_match;
    lupp_pkg::idx_t      found_cell;
    lupp_pkg::chain_t    best;

    logic                accept;
    logic                load_done;
    lupp_pkg::dim_t      n_clamp;
    logic                div_start;
    logic                div_done;
    lupp_pkg::word_t     div_q;
    logic signed [47:0]  prod_sh;
    logic signed [48:0]  diff;
    lupp_pkg::word_t     upd_val;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign best   = chain_link[DIM];
    assign chain_link[0] = '0;

    assign load_done = (ld_col_reg + 4'd1 == n_reg) && (ld_row_reg + 4'd1 == n_reg);

    always_comb
    begin
        if (cfg_wr_data == 4'd0)
            n_clamp = 4'd1;
        else if (cfg_wr_data > lupp_pkg::DIM_W'(DIM))
            n_clamp = lupp_pkg::DIM_W'(DIM);
        else
            n_clamp = cfg_wr_data;
    end

    always_comb
    begin
        found_cell = '0;
        for (int c = 0; c < DIM; c++)
        begin
            if (cell_match[c])
                found_cell = lupp_pkg::IDX_W'(c);
        end
    end

    always_comb
    begin
        prod_sh = prod_reg[63:16];
        diff    = 49'(signed'({{17{a_reg[31]}}, a_reg})) - 49'(signed'({prod_sh[47], prod_sh}));
        upd_val = lupp_pkg::sat_word(diff);
    end

    always_comb
    begin
        ctl       = '0;
        ctl.k     = k_reg[2:0];
        ctl.n     = n_reg;
        ctl.rd_col = k_reg[2:0];
        div_start = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                ctl.w_we      = accept;
                ctl.wr_cell   = ld_row_reg[2:0];
                ctl.wr_col    = ld_col_reg[2:0];
                ctl.wr_data   = element;
                ctl.lpos_init = accept && load_done;
            end
            S_PIVOT:
            begin
                ctl.swap_en = 1'b1;
                ctl.swap_a  = k_reg[2:0];
                ctl.swap_b  = best.best_pos;
            end
            S_ROW:
            begin
                ctl.find_pos = i_reg[2:0];
            end
            S_DSTART:
            begin
                div_start = 1'b1;
            end
            S_DIV:
            begin
                ctl.l_we    = div_done;
                ctl.wr_cell = cur_cell_reg;
                ctl.wr_col  = k_reg[2:0];
                ctl.wr_data = div_q;
            end
            S_MUL:
            begin
                ctl.rd_col = j_reg[2:0];
            end
            S_SUB:
            begin
                ctl.w_we    = 1'b1;
                ctl.wr_cell = cur_cell_reg;
                ctl.wr_col  = j_reg[2:0];
                ctl.wr_data = upd_val;
            end
            S_OROW:
            begin
                ctl.find_pos = i_reg[2:0];
            end
            S_OCOL:
            begin
                ctl.rd_col = j_reg[2:0];
            end
            default:
            begin
                ctl.rd_col = k_reg[2:0];
            end
        endcase
    end

    for (genvar g = 0; g < DIM; g++)
    begin : g_cell
        lupp_cell #(
            .CELL_ID (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .chain_in  (chain_link[g]),
            .chain_out (chain_link[g+1]),
            .rd_w      (cell_w[g]),
            .rd_l      (cell_l[g]),
            .match     (cell_match[g])
        );
    end

    lupp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cell_w[cur_cell_reg]),
        .divisor  (pv_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            n_reg            <= lupp_pkg::DIM_W'(DIM);
            ld_row_reg       <= '0;
            ld_col_reg       <= '0;
            k_reg            <= '0;
            i_reg            <= '0;
            j_reg            <= '0;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg_wr_en)
                    begin
                        n_reg      <= n_clamp;
                        ld_row_reg <= '0;
                        ld_col_reg <= '0;
                    end
                    else if (accept)
                    begin
                        if (load_done)
                        begin
                            ld_row_reg <= '0;
                            ld_col_reg <= '0;
                            k_reg      <= '0;
                            cnt_reg    <= '0;
                            state_reg  <= S_SEARCH;
                        end
                        else if (ld_col_reg + 4'd1 == n_reg)
                        begin
                            ld_col_reg <= '0;
                            ld_row_reg <= ld_row_reg + 4'd1;
                        end
                        else
                            ld_col_reg <= ld_col_reg + 4'd1;
                    end
                end
                S_SEARCH:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == lupp_pkg::DIM_W'(DIM))
                    begin
                        if (best.found)
                            state_reg <= S_PIVOT;
                        else
                        begin
                            result_valid_reg <= 1'b1;
                            state_reg        <= S_IDLE;
                        end
                    end
                end
                S_PIVOT:
                begin
                    i_reg     <= k_reg + 4'd1;
                    state_reg <= S_ROW;
                end
                S_ROW:
                begin
                    if (i_reg == n_reg)
                    begin
                        if (k_reg + 4'd1 == n_reg)
                        begin
                            i_reg     <= '0;
                            state_reg <= S_OROW;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 4'd1;
                            cnt_reg   <= '0;
                            state_reg <= S_SEARCH;
                        end
                    end
                    else
                        state_reg <= S_DSTART;
                end
                S_DSTART:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        j_reg     <= k_reg + 4'd1;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_SUB;
                end
                S_SUB:
                begin
                    if (j_reg + 4'd1 == n_reg)
                    begin
                        i_reg     <= i_reg + 4'd1;
                        state_reg <= S_ROW;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 4'd1;
                        state_reg <= S_MUL;
                    end
                end
                S_OROW:
                begin
                    j_reg     <= '0;
                    state_reg <= S_OCOL;
                end
                S_OCOL:
                begin
                    result_valid_reg <= 1'b1;
                    if (j_reg + 4'd1 == n_reg)
                    begin
                        j_reg <= '0;
                        if (i_reg + 4'd1 == n_reg)
                            state_reg <= S_IDLE;
                        else
                        begin
                            i_reg     <= i_reg + 4'd1;
                            state_reg <= S_OROW;
                        end
                    end
                    else
                        j_reg <= j_reg + 4'd1;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_PIVOT)
        begin
            pv_reg       <= cell_w[best.best_cell];
            piv_cell_reg <= best.best_cell;
        end
        if ((state_reg == S_ROW) || (state_reg == S_OROW))
            cur_cell_reg <= found_cell;
        if ((state_reg == S_DIV) && div_done)
            lq_reg <= div_q;
        if (state_reg == S_MUL)
        begin
            prod_reg <= 64'(lq_reg) * 64'(cell_w[piv_cell_reg]);
            a_reg    <= cell_w[cur_cell_reg];
        end
        if ((state_reg == S_SEARCH) && (cnt_reg == lupp_pkg::DIM_W'(DIM)) && !best.found)
        begin
            // zero pivot column
            row_index_reg    <= k_reg[2:0];
            col_index_reg    <= k_reg[2:0];
            lower_value_reg  <= lupp_pkg::ZERO_Q16;
            upper_value_reg  <= lupp_pkg::ZERO_Q16;
            original_row_reg <= '0;
            singular_reg     <= 1'b1;
            last_reg         <= 1'b1;
        end
        else if (state_reg == S_OCOL)
        begin
            row_index_reg    <= i_reg[2:0];
            col_index_reg    <= j_reg[2:0];
            if (j_reg < i_reg)
                lower_value_reg <= cell_l[cur_cell_reg];
            else if (j_reg == i_reg)
                lower_value_reg <= lupp_pkg::ONE_Q16;
            else
                lower_value_reg <= lupp_pkg::ZERO_Q16;
            upper_value_reg  <= (j_reg >= i_reg) ? cell_w[cur_cell_reg] : lupp_pkg::ZERO_Q16;
            original_row_reg <= cur_cell_reg;
            singular_reg     <= 1'b0;
            last_reg         <= (i_reg + 4'd1 == n_reg) && (j_reg + 4'd1 == n_reg);
        end
    end

    assign result_valid = result_valid_reg;
    assign row_index    = row_index_reg;
    assign col_index    = col_index_reg;
    assign lower_value  = lower_value_reg;
    assign upper_value  = upper_value_reg;
    assign original_row = original_row_reg;
    assign singular     = singular_reg;
    assign last         = last_reg;

endmodule

/* src/lupp_cell.sv */
// ----------------------------------------------------------------------------
// lupp_cell
// one matrix row cell: row words, lower factor row, logical position, and
// one stage of the pivot search chain
// ----------------------------------------------------------------------------
module lupp_cell #(
    parameter int CELL_ID = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lupp_pkg::cell_ctl_t  ctl,
    input  lupp_pkg::chain_t     chain_in,
    output lupp_pkg::chain_t     chain_out,
    output lupp_pkg::word_t      rd_w,
    output lupp_pkg::word_t      rd_l,
    output logic                 match
);

    localparam lupp_pkg::idx_t ID = lupp_pkg::IDX_W'(CELL_ID);

    lupp_pkg::word_t  w_reg [lupp_pkg::MAX_DIM];
    lupp_pkg::word_t  l_reg [lupp_pkg::MAX_DIM];
    lupp_pkg::idx_t   lpos_reg;
    lupp_pkg::chain_t chain_reg;
    lupp_pkg::chain_t chain_next;
    logic [31:0]      mag;
    logic             eligible;
    logic             take;

    assign rd_w      = w_reg[ctl.rd_col];
    assign rd_l      = l_reg[ctl.rd_col];
    assign match     = (lpos_reg == ctl.find_pos);
    assign chain_out = chain_reg;

    always_comb
    begin
        mag      = lupp_pkg::abs_word(rd_w);
        eligible = (lpos_reg >= ctl.k) && ({1'b0, lpos_reg} < ctl.n);
        take     = eligible && (mag != 32'd0) &&
                   (!chain_in.found || (mag > chain_in.best_abs) ||
                    ((mag == chain_in.best_abs) && (lpos_reg < chain_in.best_pos)));
        chain_next = chain_in;
        if (take)
        begin
            chain_next.found     = 1'b1;
            chain_next.best_abs  = mag;
            chain_next.best_pos  = lpos_reg;
            chain_next.best_cell = ID;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lpos_reg  <= ID;
            chain_reg <= '0;
        end
        else
        begin
            chain_reg <= chain_next;
            if (ctl.lpos_init)
                lpos_reg <= ID;
            else if (ctl.swap_en)
            begin
                if (lpos_reg == ctl.swap_a)
                    lpos_reg <= ctl.swap_b;
                else if (lpos_reg == ctl.swap_b)
                    lpos_reg <= ctl.swap_a;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.w_we && (ctl.wr_cell == ID))
            w_reg[ctl.wr_col] <= ctl.wr_data;
        if (ctl.l_we && (ctl.wr_cell == ID))
            l_reg[ctl.wr_col] <= ctl.wr_data;
    end

endmodule

/* src/lupp_div.sv */
// ----------------------------------------------------------------------------
// lupp_div
// radix-2 restoring divider, (a * 2^16) / d truncated toward zero, saturated
// ----------------------------------------------------------------------------
module lupp_div (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  lupp_pkg::word_t  dividend,
    input  lupp_pkg::word_t  divisor,
    output logic             done,
    output lupp_pkg::word_t  quotient
);

    localparam int STEPS = 48;
    localparam int CNT_W = 6;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [47:0]      num_reg;
    logic [31:0]      rem_reg;
    logic [47:0]      q_reg;
    logic [31:0]      d_reg;
    logic             neg_reg;
    logic [32:0]      rem_sh;
    logic             ge;
    logic [32:0]      rem_sub;
    logic [31:0]      neg_q;

    always_comb
    begin
        rem_sh  = {rem_reg, num_reg[47]};
        ge      = rem_sh >= {1'b0, d_reg};
        rem_sub = rem_sh - {1'b0, d_reg};
        neg_q   = ~q_reg[31:0] + 32'd1;
        if (!neg_reg)
            quotient = (q_reg > 48'h0000_7FFF_FFFF) ? lupp_pkg::WORD_MAX : q_reg[31:0];
        else
            quotient = (q_reg > 48'h0000_8000_0000) ? lupp_pkg::WORD_MIN : neg_q;
    end

    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(STEPS - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= {lupp_pkg::abs_word(dividend), 16'd0};
            d_reg   <= lupp_pkg::abs_word(divisor);
            rem_reg <= '0;
            q_reg   <= '0;
            neg_reg <= dividend[31] ^ divisor[31];
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[46:0], 1'b0};
            rem_reg <= ge ? rem_sub[31:0] : rem_sh[31:0];
            q_reg   <= {q_reg[46:0], ge};
        end
    end

endmodule

/* src/lupp_check.sv */
// ----------------------------------------------------------------------------
// lupp_check
// port-level checks for the lu factorization block
// ----------------------------------------------------------------------------
module lupp_check (
    input logic        clk,
    input logic        rst_n,
    input logic        busy,
    input logic        result_valid,
    input logic [2:0]  row_index,
    input logic [2:0]  col_index,
    input logic signed [31:0] lower_value,
    input logic signed [31:0] upper_value,
    input logic [2:0]  original_row,
    input logic        singular,
    input logic        last
);

    a_sing_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && singular |-> last)
        else $error("singular word without last");

    a_sing_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && singular |-> (row_index == col_index) && (lower_value == 32'sd0)
            && (upper_value == 32'sd0) && (original_row == 3'd0))
        else $error("singular word fields wrong");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |-> !busy)
        else $error("busy after last word");

    a_upper_tri: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !singular && (col_index > row_index) |-> lower_value == 32'sd0)
        else $error("lower factor nonzero above diagonal");

endmodule

bind lu_decomposition_partial_pivot lupp_check u_lupp_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .busy         (busy),
    .result_valid (result_valid),
    .row_index    (row_index),
    .col_index    (col_index),
    .lower_value  (lower_value),
    .upper_value  (upper_value),
    .original_row (original_row),
    .singular     (singular),
    .last         (last)
);

/* verif/lupp_checker.sv */
// ----------------------------------------------------------------------------
// lupp_checker
// predicts and checks the factorization words of the lu block
// ----------------------------------------------------------------------------
// watches the size writes and the accepted element words, keeps its own copy
// of the loaded matrix, factors it with partial pivoting in Q15.16 when the
// load completes and compares every result word field by field, in order
// ----------------------------------------------------------------------------
module lupp_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  lupp_pkg::word_t   element,
    input  logic              cfg_wr_en,
    input  lupp_pkg::dim_t    cfg_wr_data,
    input  logic              result_valid,
    input  lupp_pkg::idx_t    row_index,
    input  lupp_pkg::idx_t    col_index,
    input  lupp_pkg::word_t   lower_value,
    input  lupp_pkg::word_t   upper_value,
    input  lupp_pkg::idx_t    original_row,
    input  logic              singular,
    input  logic              last,
    output int                errors,
    output int                pending
);

    typedef struct {
        lupp_pkg::idx_t  row;
        lupp_pkg::idx_t  col;
        lupp_pkg::word_t lower;
        lupp_pkg::word_t upper;
        lupp_pkg::idx_t  orig;
        logic            sing;
        logic            fin;
    } lu_word_t;

    lu_word_t        expected_words[$];
    lupp_pkg::word_t loaded_matrix[64];
    int              load_count;
    lupp_pkg::dim_t  size_reg;

    function automatic lupp_pkg::word_t clamp_word(input longint v);
        lupp_pkg::word_t r;
        if (v > longint'(lupp_pkg::WORD_MAX))
            r = lupp_pkg::WORD_MAX;
        else if (v < longint'(lupp_pkg::WORD_MIN))
            r = lupp_pkg::WORD_MIN;
        else
            r = lupp_pkg::word_t'(v);
        return r;
    endfunction

    function automatic int active_size();
        int n;
        n = size_reg;
        if (n < 1)
            n = 1;
        if (n > lupp_pkg::MAX_DIM)
            n = lupp_pkg::MAX_DIM;
        return n;
    endfunction

    task automatic factor_matrix(input int n);
        lupp_pkg::word_t lo[64];
        int              perm[8];
        int              i, j, k, prow, tp;
        longint          best, v, pv, l, u, a;
        lupp_pkg::word_t t;
        lu_word_t        w;
        for (i = 0; i < 64; i++)
            lo[i] = lupp_pkg::ZERO_Q16;
        for (i = 0; i < 8; i++)
            perm[i] = i;
        for (k = 0; k < n; k++)
        begin
            best = 0;
            prow = -1;
            for (i = k; i < n; i++)
            begin
                v = longint'(loaded_matrix[i*n+k]);
                if (v < 0)
                    v = -v;
                if (best < v)
                begin
                    best = v;
                    prow = i;
                end
            end
            if (prow < 0)
            begin
                w = '{row: lupp_pkg::idx_t'(k), col: lupp_pkg::idx_t'(k),
                      lower: lupp_pkg::ZERO_Q16, upper: lupp_pkg::ZERO_Q16,
                      orig: '0, sing: 1'b1, fin: 1'b1};
                expected_words.push_back(w);
                return;
            end
            tp = perm[k];
            perm[k] = perm[prow];
            perm[prow] = tp;
            for (j = 0; j < n; j++)
            begin
                t = loaded_matrix[k*n+j];
                loaded_matrix[k*n+j] = loaded_matrix[prow*n+j];
                loaded_matrix[prow*n+j] = t;
            end
            for (j = 0; j < k; j++)
            begin
                t = lo[k*n+j];
                lo[k*n+j] = lo[prow*n+j];
                lo[prow*n+j] = t;
            end
            pv = longint'(loaded_matrix[k*n+k]);
            for (i = k + 1; i < n; i++)
                lo[i*n+k] = clamp_word((longint'(loaded_matrix[i*n+k]) * 65536) / pv);
            for (i = k + 1; i < n; i++)
            begin
                l = longint'(lo[i*n+k]);
                for (j = k + 1; j < n; j++)
                begin
                    u = longint'(loaded_matrix[k*n+j]);
                    a = longint'(loaded_matrix[i*n+j]);
                    loaded_matrix[i*n+j] = clamp_word(a - ((l * u) >>> 16));
                end
            end
        end
        for (i = 0; i < n; i++)
            for (j = 0; j < n; j++)
            begin
                w.row   = lupp_pkg::idx_t'(i);
                w.col   = lupp_pkg::idx_t'(j);
                w.lower = (j < i) ? lo[i*n+j] :
                          ((j == i) ? lupp_pkg::ONE_Q16 : lupp_pkg::ZERO_Q16);
                w.upper = (j >= i) ? loaded_matrix[i*n+j] : lupp_pkg::ZERO_Q16;
                w.orig  = lupp_pkg::idx_t'(perm[i]);
                w.sing  = 1'b0;
                w.fin   = (i == n - 1) && (j == n - 1);
                expected_words.push_back(w);
            end
    endtask

    function automatic int field_bad(input string name, input longint exp_v,
                                     input longint act_v);
        if (exp_v != act_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lu_word_t w;
        int       bad;
        int       n;
        if (!rst_n)
        begin
            expected_words.delete();
            load_count = 0;
            size_reg   = lupp_pkg::dim_t'(lupp_pkg::MAX_DIM);
            errors     = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                size_reg   = cfg_wr_data;
                load_count = 0;
            end
            if (start && !busy)
            begin
                loaded_matrix[load_count] = element;
                load_count = (load_count + 1) % 64;
                n = active_size();
                if (load_count == 0 || load_count >= n * n)
                begin
                    factor_matrix(n);
                    load_count = 0;
                end
            end
            if (result_valid)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("result word with nothing expected");
                    errors++;
                end
                else
                begin
                    w = expected_words.pop_front();
                    bad = field_bad("row_index", w.row, row_index)
                        + field_bad("col_index", w.col, col_index)
                        + field_bad("lower_value", w.lower, lower_value)
                        + field_bad("upper_value", w.upper, upper_value)
                        + field_bad("original_row", w.orig, original_row)
                        + field_bad("singular", w.sing, singular)
                        + field_bad("last", w.fin, last);
                    if (bad != 0)
                        errors++;
                end
            end
            pending = expected_words.size();
        end
    end

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// testbench for the lu factorization block with partial pivoting
// ----------------------------------------------------------------------------
// loads directed and random matrices of all sizes in bursts with random gaps,
// changes the size between matrices and once in the middle of a load, and
// leaves prediction and checking to the checker; gives the final verdict
// ----------------------------------------------------------------------------
module tb_top;

    logic            clk;
    logic            rst_n;
    logic            start;
    logic            busy;
    lupp_pkg::word_t element;
    logic            cfg_wr_en;
    lupp_pkg::dim_t  cfg_wr_data;
    logic            result_valid;
    lupp_pkg::idx_t  row_index;
    lupp_pkg::idx_t  col_index;
    lupp_pkg::word_t lower_value;
    lupp_pkg::word_t upper_value;
    lupp_pkg::idx_t  original_row;
    logic            singular;
    logic            last;
    int              errors;
    int              pending;
    int              words_sent;
    int              burst_left;
    int              size_now;

    lu_decomposition_partial_pivot u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .element      (element),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .result_valid (result_valid),
        .row_index    (row_index),
        .col_index    (col_index),
        .lower_value  (lower_value),
        .upper_value  (upper_value),
        .original_row (original_row),
        .singular     (singular),
        .last         (last)
    );

    lupp_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .element      (element),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .result_valid (result_valid),
        .row_index    (row_index),
        .col_index    (col_index),
        .lower_value  (lower_value),
        .upper_value  (upper_value),
        .original_row (original_row),
        .singular     (singular),
        .last         (last),
        .errors       (errors),
        .pending      (pending)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    task automatic send_word(input lupp_pkg::word_t v);
        int gap;
        if (!start)
            start <= 1'b1;
        element <= v;
        do
            @(posedge clk);
        while (busy);
        words_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic wait_idle();
        if (start)
            start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_size(input lupp_pkg::dim_t v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        if (v == 4'd0)
            size_now = 1;
        else if (int'(v) > lupp_pkg::MAX_DIM)
            size_now = lupp_pkg::MAX_DIM;
        else
            size_now = int'(v);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic lupp_pkg::word_t pick_element(input int mode);
        lupp_pkg::word_t v;
        case (mode)
            0: v = lupp_pkg::word_t'($urandom());
            1: v = lupp_pkg::word_t'($urandom_range(0, 8 * 65536))
                   - lupp_pkg::word_t'(4 * 65536);
            2: v = ($urandom_range(0, 2) == 0) ? lupp_pkg::ZERO_Q16 :
                   lupp_pkg::word_t'($urandom_range(0, 255));
            default:
                case ($urandom_range(0, 4))
                    0: v = lupp_pkg::WORD_MAX;
                    1: v = lupp_pkg::WORD_MIN;
                    2: v = lupp_pkg::ZERO_Q16;
                    3: v = lupp_pkg::ONE_Q16;
                    default: v = -lupp_pkg::ONE_Q16;
                endcase
        endcase
        return v;
    endfunction

    task automatic send_matrix(input int n, input int mode, input int zero_col);
        int i, j;
        for (i = 0; i < n; i++)
            for (j = 0; j < n; j++)
                send_word((j == zero_col) ? lupp_pkg::ZERO_Q16 : pick_element(mode));
        wait_idle();
    endtask

    initial
    begin
        int             n;
        lupp_pkg::dim_t sz;
        rst_n       = 1'b0;
        start       = 1'b0;
        element     = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        words_sent  = 0;
        burst_left  = 4;
        size_now    = lupp_pkg::MAX_DIM;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single element, zero then most negative
        write_size(4'd1);
        send_word(lupp_pkg::ZERO_Q16);
        wait_idle();
        send_word(lupp_pkg::WORD_MIN);
        wait_idle();
        // pivot swap
        write_size(4'd2);
        send_word(lupp_pkg::ONE_Q16);
        send_word(2 * lupp_pkg::ONE_Q16);
        send_word(3 * lupp_pkg::ONE_Q16);
        send_word(4 * lupp_pkg::ONE_Q16);
        wait_idle();
        // second pivot column goes to zero
        send_word(lupp_pkg::ONE_Q16);
        send_word(2 * lupp_pkg::ONE_Q16);
        send_word(2 * lupp_pkg::ONE_Q16);
        send_word(4 * lupp_pkg::ONE_Q16);
        wait_idle();
        // update saturates
        send_word(lupp_pkg::word_t'(1));
        send_word(lupp_pkg::WORD_MAX);
        send_word(-lupp_pkg::word_t'(1));
        send_word(lupp_pkg::WORD_MAX);
        wait_idle();
        // zero size acts as one
        write_size(4'd0);
        send_word(lupp_pkg::WORD_MAX);
        wait_idle();
        write_size(4'd15);
        write_size(4'd9);
        // size rewritten in the middle of a load
        write_size(4'd3);
        send_word(lupp_pkg::ONE_Q16);
        send_word(lupp_pkg::ONE_Q16);
        wait_idle();
        write_size(4'd3);
        send_matrix(3, 1, -1);

        while (words_sent < 250)
        begin
            case ($urandom_range(0, 19))
                0:       sz = lupp_pkg::dim_t'($urandom_range(9, 15));
                1:       sz = 4'd0;
                2, 3:    sz = lupp_pkg::dim_t'($urandom_range(5, 8));
                default: sz = lupp_pkg::dim_t'($urandom_range(1, 4));
            endcase
            if ($urandom_range(0, 4) != 0)
                write_size(sz);
            n = size_now;
            send_matrix(n, $urandom_range(0, 3),
                        ($urandom_range(0, 7) == 0) ? $urandom_range(0, n - 1) : -1);
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #(12 * 3000000);
        $display("FAIL");
        $finish;
    end

endmodule
